// ===== src/mrle_pkg.sv =====
// Shared constants, types and command codes for the monochrome raster engine.
package mrle_pkg;

	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 400;
	localparam int WORDS_PER_ROW = (SCREEN_WIDTH + 15) / 16;
	localparam int MEM_WORDS     = WORDS_PER_ROW * SCREEN_HEIGHT;

	// Widths of clipped coordinates, word indexes and memory addresses.
	localparam int X_W    = $clog2(SCREEN_WIDTH + 1);
	localparam int Y_W    = $clog2(SCREEN_HEIGHT + 1);
	localparam int WORD_W = X_W - 4;
	localparam int ADDR_W = $clog2(MEM_WORDS);

	// Coordinates are compared after sign extension to this width.
	localparam int CMP_W = 13;

	typedef logic [1:0]         action_t;
	typedef logic signed [10:0] coord_t;
	typedef logic [15:0]        word_t;

	localparam action_t ACT_CLEAR_RECT = 2'd0;
	localparam action_t ACT_HLINE      = 2'd1;
	localparam action_t ACT_VLINE      = 2'd2;
	localparam action_t ACT_READ_WORD  = 2'd3;

endpackage

// ===== src/mrle_cmd_if.sv =====
// Command channel interface: valid/ready handshake with the drawing command payload.
interface mrle_cmd_if;
	logic             valid;
	logic             ready;
	mrle_pkg::action_t action;
	mrle_pkg::coord_t  xa;
	mrle_pkg::coord_t  xb;
	mrle_pkg::coord_t  ya;
	mrle_pkg::coord_t  yb;

	modport source (output valid, output action, output xa, output xb, output ya,
		output yb, input ready);
	modport sink (input valid, input action, input xa, input xb, input ya, input yb,
		output ready);
endinterface

// ===== src/mrle_rsp_if.sv =====
// Response channel interface: valid/ready handshake with status and read data.
interface mrle_rsp_if;
	logic            valid;
	logic            ready;
	logic            status;
	mrle_pkg::word_t read_data;

	modport source (output valid, output status, output read_data, input ready);
	modport sink (input valid, input status, input read_data, output ready);
endinterface

// ===== src/mono_raster_rect_line_engine.sv =====
// Top level of the monochrome raster engine: command sequencer and frame memory.
//
//   channel | side | handshake        | payload
//   --------+------+------------------+---------------------------------------
//   cmd     | in   | valid / ready    | action, xa, xb, ya, yb
//   rsp     | out  | valid / ready    | status, read_data
//
// Each command is handled alone. After the transfer, the setup state orders and clips
// the coordinates; then every touched word passes through a read state and a write
// state (read, then modify and write back); a read command touches one word, and an
// off-screen command goes back to idle from setup.
// After reset the sequencer sweeps the whole frame memory to zero, one word per
// cycle (MEM_WORDS words, 16000 by default), and takes no command meanwhile.
// A result waiting on rsp blocks the next command until it has been transferred.
module mono_raster_rect_line_engine (
	input  logic         clk,
	input  logic         arst_n,
	mrle_cmd_if.sink     cmd,
	mrle_rsp_if.source   rsp
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_WR    = 3'd4;

	localparam logic signed [mrle_pkg::CMP_W-1:0] SW_S =
		mrle_pkg::CMP_W'(mrle_pkg::SCREEN_WIDTH);
	localparam logic signed [mrle_pkg::CMP_W-1:0] SH_S =
		mrle_pkg::CMP_W'(mrle_pkg::SCREEN_HEIGHT);
	localparam logic signed [mrle_pkg::CMP_W-1:0] ZERO_S = '0;
	localparam logic signed [mrle_pkg::CMP_W-1:0] ONE_S = mrle_pkg::CMP_W'(1);

	logic [2:0] state_q;
	logic [mrle_pkg::ADDR_W-1:0] init_cnt_q;

	// Captured command.
	mrle_pkg::action_t act_q;
	mrle_pkg::coord_t  xa_q, xb_q, ya_q, yb_q;

	// Walk state: word range and edge pixels of the span, current row and word.
	logic [mrle_pkg::WORD_W-1:0] ws_q, wf_q, w_q;
	logic [3:0]                  lo_q, hi_q;
	logic [mrle_pkg::Y_W-1:0]    row_q, y1_q;
	logic [mrle_pkg::ADDR_W-1:0] row_base_q, addr_q;

	// Frame memory and its registered read port.
	mrle_pkg::word_t mem [mrle_pkg::MEM_WORDS];
	mrle_pkg::word_t rd_data_q;
	logic                        mem_we;
	logic [mrle_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
	mrle_pkg::word_t             mem_wdata;

	// Output register.
	logic            out_valid_q;
	logic            status_q;
	mrle_pkg::word_t read_data_q;

	assign cmd.ready     = (state_q == ST_IDLE) && !out_valid_q;
	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.read_data = read_data_q;

	// Setup: pick the x and y spans for the action, then order and clip them.
	// A single coordinate is used as a span of one so that all four actions share
	// the same off-screen test.
	logic signed [mrle_pkg::CMP_W-1:0] xa_e, xb_e, ya_e, yb_e;
	logic signed [mrle_pkg::CMP_W-1:0] ex0, ex1, ey0, ey1;
	logic signed [mrle_pkg::CMP_W-1:0] x0_cl, x1_cl, y0_cl, y1_cl;
	logic                              off_screen;
	logic [mrle_pkg::X_W-1:0]          x0_u, x1_u;
	logic [mrle_pkg::Y_W-1:0]          y0_u, y1_u;

	always_comb begin
		xa_e = mrle_pkg::CMP_W'(xa_q);
		xb_e = mrle_pkg::CMP_W'(xb_q);
		ya_e = mrle_pkg::CMP_W'(ya_q);
		yb_e = mrle_pkg::CMP_W'(yb_q);
		ex0 = (xa_e < xb_e) ? xa_e : xb_e;
		ex1 = (xa_e < xb_e) ? xb_e : xa_e;
		ey0 = (ya_e < yb_e) ? ya_e : yb_e;
		ey1 = (ya_e < yb_e) ? yb_e : ya_e;
		case (act_q)
			mrle_pkg::ACT_CLEAR_RECT: begin
			end
			mrle_pkg::ACT_HLINE: begin
				ey0 = ya_e;
				ey1 = ya_e;
			end
			mrle_pkg::ACT_VLINE: begin
				ex0 = xa_e;
				ex1 = xa_e;
			end
			default: begin
				ex0 = xa_e;
				ex1 = xa_e;
				ey0 = ya_e;
				ey1 = ya_e;
			end
		endcase
		off_screen = (ex0 >= SW_S) || (ex1 < ZERO_S) || (ey0 >= SH_S) || (ey1 < ZERO_S);
		x0_cl = (ex0 < ZERO_S) ? ZERO_S : ex0;
		x1_cl = (ex1 >= SW_S) ? (SW_S - ONE_S) : ex1;
		y0_cl = (ey0 < ZERO_S) ? ZERO_S : ey0;
		y1_cl = (ey1 >= SH_S) ? (SH_S - ONE_S) : ey1;
		x0_u = x0_cl[mrle_pkg::X_W-1:0];
		x1_u = x1_cl[mrle_pkg::X_W-1:0];
		y0_u = y0_cl[mrle_pkg::Y_W-1:0];
		y1_u = y1_cl[mrle_pkg::Y_W-1:0];
	end

	// Edge masks apply only on the first and last word of the span; pixel x sits
	// at bit 15 - (x & 15).
	logic [3:0]      lo_eff, hi_eff;
	mrle_pkg::word_t span_mask, new_word;

	always_comb begin
		lo_eff    = (w_q == ws_q) ? lo_q : 4'd0;
		hi_eff    = (w_q == wf_q) ? hi_q : 4'd15;
		span_mask = (16'hFFFF >> lo_eff) & (16'hFFFF << (4'd15 - hi_eff));
		if (act_q == mrle_pkg::ACT_CLEAR_RECT) begin
			new_word = rd_data_q & ~span_mask;
		end else begin
			new_word = rd_data_q | span_mask;
		end
	end

	// Memory port control: the reset sweep owns the write port, otherwise the
	// write-back step of the walk does.
	always_comb begin
		mem_raddr = mrle_pkg::ADDR_W'(row_base_q + mrle_pkg::ADDR_W'(w_q));
		if (state_q == ST_INIT) begin
			mem_we    = 1'b1;
			mem_waddr = init_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_we    = (state_q == ST_WR) && (act_q != mrle_pkg::ACT_READ_WORD);
			mem_waddr = addr_q;
			mem_wdata = new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					init_cnt_q <= init_cnt_q + 1'b1;
					if (init_cnt_q == mrle_pkg::ADDR_W'(mrle_pkg::MEM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (off_screen) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if ((w_q == wf_q) && (row_q == y1_q)) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the walk and the result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid && cmd.ready) begin
					act_q <= cmd.action;
					xa_q  <= cmd.xa;
					xb_q  <= cmd.xb;
					ya_q  <= cmd.ya;
					yb_q  <= cmd.yb;
				end
			end
			ST_SETUP: begin
				ws_q       <= x0_u[mrle_pkg::X_W-1:4];
				wf_q       <= x1_u[mrle_pkg::X_W-1:4];
				w_q        <= x0_u[mrle_pkg::X_W-1:4];
				lo_q       <= x0_u[3:0];
				hi_q       <= x1_u[3:0];
				row_q      <= y0_u;
				y1_q       <= y1_u;
				row_base_q <= mrle_pkg::ADDR_W'(y0_u * mrle_pkg::WORDS_PER_ROW);
				status_q   <= off_screen;
				read_data_q <= '0;
			end
			ST_RD: begin
				addr_q <= mem_raddr;
			end
			ST_WR: begin
				if (act_q == mrle_pkg::ACT_READ_WORD) begin
					read_data_q <= rd_data_q;
				end
				if (w_q == wf_q) begin
					if (row_q != y1_q) begin
						row_q      <= row_q + 1'b1;
						row_base_q <= mrle_pkg::ADDR_W'(row_base_q +
							mrle_pkg::ADDR_W'(mrle_pkg::WORDS_PER_ROW));
						w_q        <= ws_q;
					end
				end else begin
					w_q <= w_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
